[hdl/mwpg_pkg.sv]
// Shared types, constants and the quarter-wave sine entry function
// for the multi-waveform phase generator. No dependencies.
package mwpg_pkg;

    localparam int ELAPSED_W  = 16;
    localparam int STEP_W     = 48;
    localparam int WAVEFORM_W = 3;
    localparam int SAMPLE_W   = 12;
    localparam int MAG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int FRAC_W     = 32;

    localparam logic [STEP_W-1:0]     STEP_RESET = 48'd3;
    localparam logic [SAMPLE_W-1:0]   MV_MID     = 12'd1650;
    localparam logic [SAMPLE_W-1:0]   MV_FULL    = 12'd3300;
    localparam logic [SAMPLE_W:0]     TRI_PEAK   = 13'd3300;
    localparam logic [SAMPLE_W:0]     TRI_FOLD   = 13'd6600;
    localparam logic [SAMPLE_W-1:0]   MV_ZERO    = 12'd0;
    localparam logic [63:0]           HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [WAVEFORM_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_TRIANGLE = 3'd3
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVEFORM   = 2'd0,
        CFG_PHASE_STEP = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [WAVEFORM_W-1:0] waveform;
        logic [STEP_W-1:0]     phase_step;
    } t_cfg;

    // Sine magnitude in millivolts (0..1650) for a Q2.30 angle x, from a
    // ten-term Taylor series. Evaluated only at elaboration.
    function automatic logic [MAG_W-1:0] quarter_mag(input logic [63:0] x);
        logic [63:0]  x2;
        logic [63:0]  t;
        longint       sum;
        logic [63:0]  e;
        x2 = (x * x) >> 30;
        t = x;
        sum = longint'(x);
        t = ((t * x2) >> 30) / 64'd6;   sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 64'd20;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 64'd42;  sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 64'd72;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 64'd110; sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 64'd156; sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 64'd210; sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 64'd272; sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 64'd342; sum = sum - longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        e = ((64'(sum) * 64'd1650) + (64'd1 << 29)) >> 30;
        if (e > 64'd1650) begin
            e = 64'd1650;
        end
        return e[MAG_W-1:0];
    endfunction

endpackage

[hdl/mwpg_if.sv]
// Handshake channel interfaces: tick items in, samples out, register writes.
// Depends on mwpg_pkg for field widths.
interface mwpg_item_if;
    logic                                valid;
    logic                                ready;
    logic                                level;
    logic [mwpg_pkg::ELAPSED_W-1:0]      elapsed_ns;
    modport source (output valid, output level, output elapsed_ns, input ready);
    modport sink   (input valid, input level, input elapsed_ns, output ready);
endinterface

interface mwpg_sample_if;
    logic                                valid;
    logic                                ready;
    logic [mwpg_pkg::SAMPLE_W-1:0]       sample_mv;
    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface mwpg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mwpg_pkg::CFG_IDX_W-1:0]      index;
    logic [mwpg_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mwpg_front.sv]
// Front end: takes tick beats, drops those with level zero, pushes the
// elapsed time into the queue, and holds the configuration registers.
// Depends on mwpg_pkg and mwpg_if.
module mwpg_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mwpg_item_if.sink                        i_item,
    mwpg_cfg_if.sink                         i_cfg,
    input  logic                             i_full,
    output logic                             o_push,
    output logic [mwpg_pkg::ELAPSED_W-1:0]   o_push_data,
    output mwpg_pkg::t_cfg                   o_cfg
);

    logic [mwpg_pkg::WAVEFORM_W-1:0] r_waveform;
    logic [mwpg_pkg::STEP_W-1:0]     r_phase_step;

    assign i_item.ready = !i_full;
    assign i_cfg.ready  = 1'b1;

    // Level-zero beats are taken and discarded without touching the queue.
    assign o_push      = i_item.valid && !i_full && i_item.level;
    assign o_push_data = i_item.elapsed_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform   <= mwpg_pkg::WAVE_SINE;
            r_phase_step <= mwpg_pkg::STEP_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == mwpg_pkg::CFG_WAVEFORM) begin
                r_waveform <= i_cfg.data[mwpg_pkg::WAVEFORM_W-1:0];
            end else if (i_cfg.index == mwpg_pkg::CFG_PHASE_STEP) begin
                r_phase_step <= i_cfg.data[mwpg_pkg::STEP_W-1:0];
            end
        end
    end

    assign o_cfg.waveform   = r_waveform;
    assign o_cfg.phase_step = r_phase_step;

endmodule

[hdl/mwpg_queue.sv]
// Two-entry FIFO that decouples the front end from the sample pipeline.
// No package dependencies.
module mwpg_queue #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             w_do_pop;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_data   = r_mem[r_rd];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_do_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/mwpg_back.sv]
// Back end: five-stage sample pipeline (step product, phase accumulate,
// saw and table index, quarter-wave lookup, shape select into the output
// register). The whole pipeline holds while the output register is stalled.
// Depends on mwpg_pkg and mwpg_if.
module mwpg_back #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mwpg_pkg::t_cfg                   i_cfg,
    input  logic                             i_q_valid,
    input  logic [mwpg_pkg::ELAPSED_W-1:0]   i_q_data,
    output logic                             o_pop,
    mwpg_sample_if.source                    o_sample
);

    localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int KPW  = 30 + AW;
    localparam int PW   = mwpg_pkg::ELAPSED_W + mwpg_pkg::STEP_W;
    localparam int SPW  = mwpg_pkg::FRAC_W + mwpg_pkg::SAMPLE_W;
    localparam int SW   = mwpg_pkg::SAMPLE_W;

    logic [mwpg_pkg::MAG_W-1:0] w_quarter [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [63:0] X =
            (mwpg_pkg::HALF_PI_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
        assign w_quarter[g] = mwpg_pkg::quarter_mag(X);
    end

    logic                       w_en;
    logic [PW-1:0]              w_prod;
    logic [mwpg_pkg::FRAC_W-1:0] w_f;
    logic [KPW-1:0]             w_kprod;
    logic [SPW-1:0]             w_sawprod;
    logic [AW-1:0]              w_addr;
    logic [SW-1:0]              w_sine;
    logic [SW:0]                w_tri2;
    logic [SW-1:0]              w_tri;
    logic [SW-1:0]              n_sample;

    logic                       r_s1_valid;
    logic [PHASE_BITS-1:0]      r_s1_prod;
    logic                       r_s2_valid;
    logic [PHASE_BITS-1:0]      r_acc;
    logic                       r_s3_valid;
    logic [SW-1:0]              r_s3_saw;
    logic [1:0]                 r_s3_quad;
    logic [AW-1:0]              r_s3_k;
    logic                       r_s4_valid;
    logic [SW-1:0]              r_s4_saw;
    logic [1:0]                 r_s4_quad;
    logic [mwpg_pkg::MAG_W-1:0] r_s4_mag;
    logic                       r_out_valid;
    logic [SW-1:0]              r_sample;

    assign w_en  = !r_out_valid || o_sample.ready;
    assign o_pop = w_en && i_q_valid;

    assign w_prod    = PW'(i_q_data) * PW'(i_cfg.phase_step);
    assign w_f       = r_acc[PHASE_BITS-1 -: mwpg_pkg::FRAC_W];
    assign w_kprod   = KPW'(w_f[29:0]) * KPW'(SINE_TABLE_DEPTH);
    assign w_sawprod = SPW'(w_f) * SPW'(mwpg_pkg::MV_FULL);
    // Odd quadrants walk the quarter table backwards.
    assign w_addr    = r_s3_quad[0] ? (AW'(SINE_TABLE_DEPTH) - r_s3_k) : r_s3_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (w_en) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
            if (r_s1_valid) begin
                r_acc <= r_acc + r_s1_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_prod <= w_prod[PHASE_BITS-1:0];
            r_s3_saw  <= w_sawprod[SPW-1:mwpg_pkg::FRAC_W];
            r_s3_quad <= w_f[31:30];
            r_s3_k    <= w_kprod[KPW-1:30];
            r_s4_saw  <= r_s3_saw;
            r_s4_quad <= r_s3_quad;
            r_s4_mag  <= w_quarter[w_addr];
            r_sample  <= n_sample;
        end
    end

    assign w_sine = r_s4_quad[1] ? (mwpg_pkg::MV_MID - SW'(r_s4_mag))
                                 : (mwpg_pkg::MV_MID + SW'(r_s4_mag));
    assign w_tri2 = {r_s4_saw, 1'b0};
    assign w_tri  = (w_tri2 > mwpg_pkg::TRI_PEAK) ? SW'(mwpg_pkg::TRI_FOLD - w_tri2)
                                                   : w_tri2[SW-1:0];

    always_comb begin
        case (i_cfg.waveform)
            mwpg_pkg::WAVE_SINE:     n_sample = w_sine;
            // The sine lies above mid-level only in the first half period.
            mwpg_pkg::WAVE_SQUARE:   n_sample = (!r_s4_quad[1] && (r_s4_mag != '0))
                                                ? mwpg_pkg::MV_FULL : mwpg_pkg::MV_ZERO;
            mwpg_pkg::WAVE_SAW:      n_sample = r_s4_saw;
            mwpg_pkg::WAVE_TRIANGLE: n_sample = w_tri;
            default:                 n_sample = mwpg_pkg::MV_ZERO;
        endcase
    end

    assign o_sample.valid     = r_out_valid;
    assign o_sample.sample_mv = r_sample;

endmodule

[hdl/multi_waveform_phase_generator_top.sv]
// Multi-waveform phase generator: a phase accumulator drives sine, square,
// saw and triangle samples in millivolts.
// Usage:
//   i_item  carries tick beats (level, elapsed_ns). A beat with level 1
//           advances the phase by elapsed_ns * phase_step and yields one
//           sample; a beat with level 0 is taken and yields nothing.
//   o_sample carries one 12-bit sample_mv (0..3300) per level-1 beat.
//   i_cfg   writes register 0 (waveform, 3 bits) or 1 (phase_step, 48 bits);
//           other indexes are ignored. Write only while no sample is pending.
// The pipeline sustains one beat per cycle while o_sample is not stalled;
// the registered phase accumulate and the registered quarter-wave lookup
// set that pace.
// When o_sample stalls, the whole back pipeline holds, the two-entry queue
// fills, and i_item.ready drops once it is full.
// Reset (synchronous, active low) clears the phase, sets waveform to sine
// and phase_step to 3, and empties the queue and pipeline.
// Depends on mwpg_pkg, mwpg_if, mwpg_front, mwpg_queue and mwpg_back.
module multi_waveform_phase_generator_top #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mwpg_item_if.sink     i_item,
    mwpg_cfg_if.sink      i_cfg,
    mwpg_sample_if.source o_sample
);

    logic                            w_push;
    logic [mwpg_pkg::ELAPSED_W-1:0]  w_push_data;
    logic                            w_full;
    logic                            w_pop;
    logic                            w_q_valid;
    logic [mwpg_pkg::ELAPSED_W-1:0]  w_q_data;
    mwpg_pkg::t_cfg                  w_cfg;

    mwpg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg       (i_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_cfg       (w_cfg)
    );

    mwpg_queue #(
        .WIDTH (mwpg_pkg::ELAPSED_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    mwpg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_sample  (o_sample)
    );

endmodule

[hdl/mwpg_checker.sv]
// Port-level checks for the multi-waveform phase generator, bound to the
// top level. Depends on mwpg_pkg.
module mwpg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [mwpg_pkg::SAMPLE_W-1:0]   i_sample_mv
);

    // A sample beat waits until the receiver takes it.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("sample beat dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_sample_mv))
        else $error("sample changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample_mv <= mwpg_pkg::MV_FULL))
        else $error("sample above full scale");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("sample pending right after reset");

endmodule

bind multi_waveform_phase_generator_top mwpg_checker u_mwpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_sample_mv (o_sample.sample_mv)
);
